@@ rtl/core/ple_pkg.sv @@
package ple_pkg;

   localparam int DATA_W     = 32;
   localparam int POS_W      = 5;
   localparam int CNT_OUT_W  = 5;
   localparam int GROUP_SIZE = 32;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_DELETE = 2'd1,
      ACT_READ   = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // broadcast to every cell of the chain
   typedef struct packed {
      logic              shift_in;   // open a slot at pos, load value there
      logic              shift_out;  // close the slot at pos
      logic [DATA_W-1:0] value;
   } cell_cmd_type;

endpackage

@@ rtl/core/ple_cell.sv @@
module ple_cell #(
   parameter int WIDE_W = 5,
   parameter int INDEX  = 0
) (
   input  logic                       clock,
   input  ple_pkg::cell_cmd_type      cmd,
   input  logic [WIDE_W-1:0]          pos,
   input  logic [ple_pkg::DATA_W-1:0] left_value,
   input  logic [ple_pkg::DATA_W-1:0] right_value,
   output logic [ple_pkg::DATA_W-1:0] value_out,
   output logic [ple_pkg::DATA_W-1:0] hit_value
);
   import ple_pkg::*;

   localparam logic [WIDE_W-1:0] MyIndex = WIDE_W'(INDEX);

   logic [DATA_W-1:0] value_ff;
   logic [DATA_W-1:0] value_in;

   always_comb begin
      priority if (cmd.shift_in && (MyIndex > pos)) begin
         value_in = left_value;
      end else if (cmd.shift_in && (MyIndex == pos)) begin
         value_in = cmd.value;
      end else if (cmd.shift_out && (MyIndex >= pos)) begin
         value_in = right_value;
      end else begin
         value_in = value_ff;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   // only the addressed cell shows its value on the gather tree
   assign hit_value = (MyIndex == pos) ? value_ff : '0;

endmodule

@@ rtl/core/ple_gather.sv @@
module ple_gather #(
   parameter int LEAVES = 32
) (
   input  logic                                   clock,
   input  logic                                   enable,
   input  logic [LEAVES-1:0][ple_pkg::DATA_W-1:0] leaf,
   output logic [ple_pkg::DATA_W-1:0]             or_out
);
   import ple_pkg::*;

   logic [DATA_W-1:0] or_ff;
   logic [DATA_W-1:0] or_in;

   always_comb begin
      or_in = '0;
      for (int i = 0; i < LEAVES; i++) begin
         or_in = or_in | leaf[i];
      end
   end

   // capture on the accepting edge, before the cells move
   always_ff @(posedge clock) begin
      if (enable) begin
         or_ff <= or_in;
      end
   end

   assign or_out = or_ff;

endmodule

@@ rtl/core/positional_list_engine.sv @@
// Positional list engine: an ordered list of up to LIST_DEPTH signed 32-bit values held
// in a row of cells, one value per cell, head in cell 0. Each transaction inserts a value
// at a position (0 to count), deletes the entry at a position (0 to count-1), or reads it.
// Every transaction returns one response: the value involved (the inserted value echoed,
// the removed or read value), a status (done, list full, position out of range) and the
// count after the transaction. Rejected transactions leave the list untouched. The block
// accepts one transaction per clock unless the response side stalls: on the accepting
// edge all cells shift in parallel toward the tail or head, while the addressed cell's
// old value is captured into group registers of up to 32 cells each; when stage 1
// advances, the group registers are OR-ed into the response register. The response
// register decouples the two sides, so a stalled response still lets one more
// transaction in. The list is empty after reset; no clearing pass is needed.
module positional_list_engine #(
   parameter int LIST_DEPTH = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [ple_pkg::POS_W-1:0]          req_position,
   input  logic signed [ple_pkg::DATA_W-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [ple_pkg::DATA_W-1:0]  rsp_result_value,
   output logic [1:0]                         rsp_status,
   output logic [ple_pkg::CNT_OUT_W-1:0]      rsp_count_after
);
   import ple_pkg::*;

   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
   localparam int WIDE_W     = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int NUM_GROUPS = (LIST_DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

   // list occupancy
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   // stage 1: decoded response fields, waiting for the gather tree
   logic              s1_valid_ff;
   logic              s1_from_list_ff;
   logic [DATA_W-1:0] s1_echo_ff;
   status_type        s1_status_ff;
   logic [CNT_W-1:0]  s1_count_ff;

   // response register
   logic                 rsp_valid_ff;
   logic [DATA_W-1:0]    rsp_value_ff;
   logic [DATA_W-1:0]    rsp_value_in;
   status_type           rsp_status_ff;
   logic [CNT_OUT_W-1:0] rsp_count_ff;
   logic [CNT_OUT_W-1:0] rsp_count_in;
   logic [WIDE_W-1:0]    s1_count_wide;

   // decode
   logic              accept;
   logic              s1_move;
   logic [WIDE_W-1:0] pos_w;
   logic [WIDE_W-1:0] cnt_w;
   logic              list_full;
   logic              from_list_in;
   logic [DATA_W-1:0] echo_in;
   status_type        status_in;
   logic              do_insert;
   logic              do_delete;
   cell_cmd_type      cmd;

   // cell chain and gather tree
   logic [LIST_DEPTH-1:0][DATA_W-1:0] cell_value;
   logic [LIST_DEPTH-1:0][DATA_W-1:0] cell_hit;
   logic [LIST_DEPTH-1:0][DATA_W-1:0] left_bus;
   logic [LIST_DEPTH-1:0][DATA_W-1:0] right_bus;
   logic [NUM_GROUPS-1:0][DATA_W-1:0] group_or;
   logic [DATA_W-1:0]                 gathered;

   // ---------------------------------------------------------------- handshake
   // advance stage 1 whenever the response register is empty or being drained
   assign s1_move   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || s1_move;
   assign accept    = req_valid && req_ready;

   // ---------------------------------------------------------------- decode
   assign pos_w     = WIDE_W'(req_position);
   assign cnt_w     = WIDE_W'(count_ff);
   assign list_full = (cnt_w == WIDE_W'(LIST_DEPTH));

   always_comb begin
      from_list_in = 1'b0;
      echo_in      = '0;
      status_in    = ST_RANGE;
      do_insert    = 1'b0;
      do_delete    = 1'b0;
      unique case (req_action)
         ACT_INSERT: begin
            // full check wins over the position check
            echo_in = req_value;
            if (list_full) begin
               status_in = ST_FULL;
            end else if (pos_w > cnt_w) begin
               status_in = ST_RANGE;
            end else begin
               status_in = ST_DONE;
               do_insert = 1'b1;
            end
         end
         ACT_DELETE: begin
            if (pos_w < cnt_w) begin
               status_in    = ST_DONE;
               from_list_in = 1'b1;
               do_delete    = 1'b1;
            end
         end
         ACT_READ: begin
            if (pos_w < cnt_w) begin
               status_in    = ST_DONE;
               from_list_in = 1'b1;
            end
         end
         default: begin
            // unused action code: report out of range, change nothing
            status_in = ST_RANGE;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (accept && do_insert) begin
         count_in = count_ff + 1'b1;
      end else if (accept && do_delete) begin
         count_in = count_ff - 1'b1;
      end
   end

   assign cmd.shift_in  = accept && do_insert;
   assign cmd.shift_out = accept && do_delete;
   assign cmd.value     = req_value;

   // ---------------------------------------------------------------- cell chain
   genvar gi;
   generate
      for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            assign left_bus[gi] = '0;
         end else begin : g_body_l
            assign left_bus[gi] = cell_value[gi-1];
         end
         if (gi == LIST_DEPTH - 1) begin : g_tail
            // the tail slot falls off on delete; hold it
            assign right_bus[gi] = cell_value[gi];
         end else begin : g_body_r
            assign right_bus[gi] = cell_value[gi+1];
         end

         ple_cell #(
            .WIDE_W (WIDE_W),
            .INDEX  (gi)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .pos         (pos_w),
            .left_value  (left_bus[gi]),
            .right_value (right_bus[gi]),
            .value_out   (cell_value[gi]),
            .hit_value   (cell_hit[gi])
         );
      end

      // first tree level: one register per group of cells
      for (gi = 0; gi < NUM_GROUPS; gi++) begin : g_group
         localparam int Lo     = gi * GROUP_SIZE;
         localparam int Leaves = ((LIST_DEPTH - Lo) < GROUP_SIZE) ?
                                 (LIST_DEPTH - Lo) : GROUP_SIZE;
         ple_gather #(
            .LEAVES (Leaves)
         ) u_gather (
            .clock  (clock),
            .enable (accept),
            .leaf   (cell_hit[Lo +: Leaves]),
            .or_out (group_or[gi])
         );
      end
   endgenerate

   // second tree level: OR of the NUM_GROUPS group registers
   always_comb begin
      gathered = '0;
      for (int g = 0; g < NUM_GROUPS; g++) begin
         gathered = gathered | group_or[g];
      end
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_from_list_ff <= from_list_in;
         s1_echo_ff      <= echo_in;
         s1_status_ff    <= status_in;
         s1_count_ff     <= count_in;
      end
   end

   // count_after is the occupancy masked to the port width
   assign s1_count_wide = WIDE_W'(s1_count_ff);
   assign rsp_count_in  = s1_count_wide[CNT_OUT_W-1:0];
   assign rsp_value_in  = s1_from_list_ff ? gathered : s1_echo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= s1_status_ff;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count_after  = rsp_count_ff;

   // ---------------------------------------------------------------- assertions
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      WIDE_W'(count_ff) <= WIDE_W'(LIST_DEPTH))
      else $error("list occupancy above depth");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && do_insert) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("committed insert did not grow the list");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && (s1_status_ff == ST_FULL)) |->
      (WIDE_W'(s1_count_ff) == WIDE_W'(LIST_DEPTH)))
      else $error("full status with a list that is not full");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (s1_valid_ff && rsp_valid_ff && !rsp_ready))
      else $error("request stalled with room in the pipeline");

endmodule

@@ tb/sv/tb_positional_list_engine.sv @@
module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int DEPTH          = 16;
   localparam int RANDOM_OPS     = 550;
   localparam int IDLE_PCT       = 13;
   localparam int QUIET_FROM     = 260;   // accepted transactions: start of the no-idle stretch
   localparam int QUIET_TO       = 380;
   localparam int DRAIN_CYCLES   = 10;    // clocks to wait after the last response, as margin
   localparam int WATCHDOG_LIMIT = 2000;

   // Action code with no operation behind it; the block must answer out of range.
   localparam logic [1:0] ACT_SPARE = 2'd3;

   typedef struct {
      logic [1:0]        action;
      logic [POS_W-1:0]  position;
      logic [DATA_W-1:0] word;
   } list_op_t;

   typedef struct {
      logic [DATA_W-1:0]    word;
      status_type           status;
      logic [CNT_OUT_W-1:0] held;
   } list_outcome_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_valid    = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_action   = '0;
   logic [POS_W-1:0]          req_position = '0;
   logic signed [DATA_W-1:0]  req_value    = '0;
   logic                      rsp_valid;
   logic                      rsp_ready    = 1'b0;
   logic signed [DATA_W-1:0]  rsp_result_value;
   logic [1:0]                rsp_status;
   logic [CNT_OUT_W-1:0]      rsp_count_after;

   // Pending operations, filled up front, drained by the request driver.
   list_op_t      op_q[$];
   // Responses the block owes, oldest first.
   list_outcome_t outcome_q[$];

   // Shadow of the list contents, updated on every accepted request.
   logic [DATA_W-1:0] shadow_list[DEPTH];
   int                shadow_count = 0;

   // Entry count as the stimulus planner sees it, used only to aim positions.
   int plan_count = 0;

   int   errors       = 0;
   int   accepted_n   = 0;
   int   idle_cycles  = 0;
   logic req_taken    = 1'b0;
   logic quiet;

   // Suppress idling on both channels for one long stretch of the run.
   assign quiet = (accepted_n >= QUIET_FROM) && (accepted_n < QUIET_TO);

   positional_list_engine #(
      .LIST_DEPTH(DEPTH)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_action       (req_action),
      .req_position     (req_position),
      .req_value        (req_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_count_after  (rsp_count_after)
   );

   always #2 clock = ~clock;

   // Apply one request to the shadow list and return the response it must produce.
   // Insert checks fullness before position; delete and read answer zero when rejected.
   function automatic list_outcome_t compute_list_outcome(logic [1:0] act,
                                                          logic [POS_W-1:0] pos,
                                                          logic [DATA_W-1:0] word);
      list_outcome_t o;
      int            i;
      int            p;
      o.word   = '0;
      o.status = ST_RANGE;
      p        = int'(pos);
      case (act)
         ACT_INSERT: begin
            o.word = word;
            if (shadow_count >= DEPTH) begin
               o.status = ST_FULL;
            end else if (p <= shadow_count) begin
               // open the slot: everything from pos moves one place toward the tail
               for (i = shadow_count; i > p; i--)
                  shadow_list[i] = shadow_list[i-1];
               shadow_list[p] = word;
               shadow_count++;
               o.status = ST_DONE;
            end
         end
         ACT_DELETE: begin
            if (p < shadow_count) begin
               o.word = shadow_list[p];
               // close the slot: everything after pos moves one place toward the head
               for (i = p; i + 1 < shadow_count; i++)
                  shadow_list[i] = shadow_list[i+1];
               shadow_count--;
               o.status = ST_DONE;
            end
         end
         ACT_READ: begin
            if (p < shadow_count) begin
               o.word   = shadow_list[p];
               o.status = ST_DONE;
            end
         end
         default: ;
      endcase
      o.held = shadow_count[CNT_OUT_W-1:0];
      return o;
   endfunction

   task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
      $display("mismatch @%0t: %s got %h want %h", $time, what, got, want);
      errors++;
   endtask

   // Favor the corner words of the value range now and then.
   function automatic logic [DATA_W-1:0] pick_word();
      case ($urandom_range(9))
         0:       return 32'h8000_0000;
         1:       return 32'h7FFF_FFFF;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Queue one operation and track the entry count it will leave behind.
   task automatic push_op(logic [1:0] act, int pos, logic [DATA_W-1:0] word);
      list_op_t op;
      op.action   = act;
      op.position = pos[POS_W-1:0];
      op.word     = word;
      op_q.push_back(op);
      if (act == ACT_INSERT && plan_count < DEPTH && pos <= plan_count)
         plan_count++;
      else if (act == ACT_DELETE && pos < plan_count)
         plan_count--;
   endtask

   // Request driver: change inputs on the falling edge only. Hold the current
   // transaction until it is accepted, then present the next one or idle.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (op_q.size() != 0 && (quiet || $urandom_range(99) >= IDLE_PCT)) begin
            req_action   <= op_q[0].action;
            req_position <= op_q[0].position;
            req_value    <= op_q[0].word;
            req_valid    <= 1'b1;
            void'(op_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response back-pressure: stall at random outside the quiet stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Monitor: sample both channels on the rising edge. Check a response against
   // the oldest owed outcome first, then predict the newly accepted request.
   always @(posedge clock) begin
      list_outcome_t want;
      req_taken <= !reset && req_valid && req_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (outcome_q.size() == 0) begin
               flag_mismatch("response with none owed", rsp_result_value, '0);
            end else begin
               want = outcome_q.pop_front();
               if (rsp_result_value !== want.word)
                  flag_mismatch("result_value", rsp_result_value, want.word);
               if (rsp_status !== want.status)
                  flag_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_count_after !== want.held)
                  flag_mismatch("count_after", 32'(rsp_count_after), 32'(want.held));
            end
         end
         if (req_valid && req_ready) begin
            outcome_q.push_back(compute_list_outcome(req_action, req_position, req_value));
            accepted_n <= accepted_n + 1;
         end
      end
   end

   // Watchdog: end the run when neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL positional_list_engine");
            $finish;
         end
      end
   end

   initial begin
      int n;
      int k;
      int roll;
      int insert_bias;

      // Directed: empty-list rejects, a full fill at head, tail and middle,
      // full-list inserts (full wins over range), tail and out-of-range reads,
      // the spare action code, then deletes at tail, head and middle.
      push_op(ACT_READ,   0, pick_word());
      push_op(ACT_DELETE, 0, pick_word());
      push_op(ACT_INSERT, 1, 32'h1234_5678);
      for (k = 0; k < DEPTH; k++) begin
         case (k % 3)
            0:       push_op(ACT_INSERT, 0, pick_word());
            1:       push_op(ACT_INSERT, plan_count, pick_word());
            default: push_op(ACT_INSERT, plan_count / 2, pick_word());
         endcase
      end
      push_op(ACT_INSERT, 0, 32'h7FFF_FFFF);
      push_op(ACT_INSERT, 31, 32'h8000_0000);
      push_op(ACT_READ,   DEPTH - 1, 32'hFFFF_FFFF);
      push_op(ACT_READ,   DEPTH, 32'h0);
      push_op(ACT_SPARE,  0, 32'h5555_AAAA);
      push_op(ACT_DELETE, DEPTH - 1, 32'h0);
      push_op(ACT_DELETE, 0, 32'h0);
      push_op(ACT_DELETE, 7, 32'h0);

      // Random: mostly in-range traffic, alternating insert-heavy and
      // delete-heavy bursts so the list swings between empty and full,
      // with a share of out-of-range positions and spare action codes.
      for (n = 0; n < RANDOM_OPS; n++) begin
         insert_bias = ((n / 40) % 2 == 0) ? 75 : 25;
         roll = $urandom_range(99);
         if (roll < 12) begin
            case ($urandom_range(3))
               0: push_op(ACT_SPARE, $urandom_range(31), pick_word());
               1: push_op(ACT_INSERT, $urandom_range(31, (plan_count < 31) ? plan_count + 1 : 31),
                          pick_word());
               2: push_op(ACT_DELETE, $urandom_range(31, plan_count), pick_word());
               default: push_op(ACT_READ, $urandom_range(31, plan_count), pick_word());
            endcase
         end else if ($urandom_range(99) < insert_bias) begin
            push_op(ACT_INSERT, $urandom_range(plan_count), pick_word());
         end else if (plan_count == 0) begin
            push_op($urandom_range(1) ? ACT_DELETE : ACT_READ, 0, pick_word());
         end else if ($urandom_range(1)) begin
            push_op(ACT_DELETE, $urandom_range(plan_count - 1), pick_word());
         end else begin
            push_op(ACT_READ, $urandom_range(plan_count - 1), pick_word());
         end
      end

      // Reset once, synchronously, then release it on a falling edge.
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait until every operation is accepted and every response is in.
      while (op_q.size() != 0 || req_valid || outcome_q.size() != 0)
         @(posedge clock);
      // Let a few more clocks pass so a stray extra response gets caught.
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (errors == 0)
         $display("PASS positional_list_engine");
      else
         $display("FAIL positional_list_engine");
      $finish;
   end

endmodule

@@ sim.f @@
rtl/core/ple_pkg.sv
rtl/core/ple_cell.sv
rtl/core/ple_gather.sv
rtl/core/positional_list_engine.sv
tb/sv/tb_positional_list_engine.sv
